/* design/mbtc_pkg.sv */
// Shared types, codes and constants for the Modbus master transaction checker.
// Used by the front, queue, back and top-level modules; depends on nothing.
package mbtc_pkg;

  localparam logic [7:0]  FC_READ       = 8'h04;
  localparam logic [7:0]  FC_WRITE1     = 8'h06;
  localparam logic [7:0]  FC_WRITEN     = 8'h10;
  localparam logic [15:0] REJECT_VALUE  = 16'hFFFF;
  localparam logic [7:0]  PAD_BYTE      = 8'h00;
  localparam logic [15:0] TIMEOUT_RESET = 16'd4000;
  localparam logic [16:0] TICKS_MAX     = 17'h1FFFF;
  localparam int          MBTC_QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_ISSUE  = 2'd0,
    KIND_REPLY  = 2'd1,
    KIND_EXCEPT = 2'd2,
    KIND_TICK   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE1 = 2'd1,
    CMD_WRITEN = 2'd2,
    CMD_BAD    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_SENT   = 3'd1,
    EV_REJECT = 3'd2,
    EV_OK     = 3'd3,
    EV_ERR    = 3'd4
  } event_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BUSY    = 3'd1,
    ST_PROTO   = 3'd2,
    ST_TIMEOUT = 3'd3,
    ST_MODBUS  = 3'd4,
    ST_INVALID = 3'd5
  } status_e;

  // Classified request as it travels from the front to the back
  typedef struct packed {
    kind_e       kind;
    cmd_e        cmd;
    logic [7:0]  func;
    logic [15:0] addr;
    logic [7:0]  expect_len;
    logic [7:0]  reg_count;
    logic [8:0]  data_bytes;
    logic [15:0] value;
    logic [7:0]  reply_len;
    logic [31:0] reply_head;
  } item_t;

  // Result fields handed to the output register
  typedef struct packed {
    event_e      ev;
    status_e     status;
    logic [7:0]  send_func;
    logic [15:0] send_address;
    logic [7:0]  send_reg_count;
    logic [8:0]  send_data_bytes;
    logic        busy;
    logic        write_wait;
  } result_t;

endpackage

/* design/mbtc_front.sv */
// Front end: accepts requests and classifies issue commands.
// Precomputes padded lengths and register counts. Depends on mbtc_pkg.
module mbtc_front (
  input  logic               in_valid_i,
  input  logic               queue_full_i,
  input  logic [1:0]         kind_i,
  input  logic [7:0]         func_code_i,
  input  logic [15:0]        reg_address_i,
  input  logic [7:0]         expect_len_i,
  input  logic [7:0]         payload_len_i,
  input  logic [15:0]        payload_word_i,
  input  logic [7:0]         reply_len_i,
  input  logic [31:0]        reply_head_i,
  output logic               push_o,
  output mbtc_pkg::item_t    item_o
);
  import mbtc_pkg::*;

  logic [8:0] padded;

  assign push_o = in_valid_i & ~queue_full_i;

  // Round the payload up to an even byte count
  assign padded = {1'b0, payload_len_i} + {8'd0, payload_len_i[0]};

  // Classify the command and derive the request fields
  always_comb begin
    item_o            = '0;
    item_o.kind       = kind_e'(kind_i);
    item_o.func       = func_code_i;
    item_o.addr       = reg_address_i;
    item_o.expect_len = expect_len_i;
    item_o.reply_len  = reply_len_i;
    item_o.reply_head = reply_head_i;
    item_o.value      = (payload_len_i == 8'd1) ? {payload_word_i[15:8], PAD_BYTE}
                                                : payload_word_i;
    if (func_code_i == FC_READ) begin
      item_o.cmd       = CMD_READ;
      item_o.reg_count = {1'b0, expect_len_i[7:1]};
    end else if (func_code_i == FC_WRITE1 && padded == 9'd2) begin
      item_o.cmd        = CMD_WRITE1;
      item_o.data_bytes = 9'd2;
    end else if (func_code_i == FC_WRITEN) begin
      item_o.cmd        = CMD_WRITEN;
      item_o.reg_count  = padded[8:1];
      item_o.data_bytes = padded;
    end else begin
      item_o.cmd = CMD_BAD;
    end
  end

endmodule

/* design/mbtc_queue.sv */
// Small request queue between the front and the back.
// Flip-flop storage with read and write pointers. Depends on mbtc_pkg.
module mbtc_queue #(
  parameter int DEPTH = mbtc_pkg::MBTC_QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mbtc_pkg::item_t push_item_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output mbtc_pkg::item_t pop_item_o
);
  import mbtc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  item_t          entry_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  count_q, count_d;

  assign full_o     = (count_q == FULL_COUNT);
  assign empty_o    = (count_q == '0);
  assign pop_item_o = entry_q[rd_ptr_q];

  // Advance pointers and track occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming request
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

/* design/mbtc_back.sv */
// Back end: transaction state machine, reply checks, tick timeout.
// Holds the timeout register and the output register. Depends on mbtc_pkg.
module mbtc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic [15:0]      cfg_data_i,
  input  logic             empty_i,
  input  mbtc_pkg::item_t  item_i,
  output logic             pop_o,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output mbtc_pkg::result_t result_o
);
  import mbtc_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_READ  = 2'd1,
    PH_WRITE = 2'd2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        pend_w1_q, pend_w1_d;
  logic [15:0] pend_addr_q, pend_addr_d;
  logic [7:0]  pend_elen_q, pend_elen_d;
  logic [15:0] pend_value_q, pend_value_d;
  logic [16:0] elapsed_q, elapsed_d;
  logic [15:0] timeout_q;
  logic        out_valid_q;
  result_t     result_q, result_d;
  logic [16:0] elapsed_inc;
  status_e     fin_st;
  logic        fin;

  // Take the next request when the output register is free or draining
  assign pop_o       = ~empty_i & (~out_valid_q | ~out_stall_i);
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  assign elapsed_inc = (elapsed_q != TICKS_MAX) ? elapsed_q + 17'd1 : elapsed_q;

  // Work out the next state and the result of this request
  always_comb begin
    phase_d      = phase_q;
    pend_w1_d    = pend_w1_q;
    pend_addr_d  = pend_addr_q;
    pend_elen_d  = pend_elen_q;
    pend_value_d = pend_value_q;
    elapsed_d    = elapsed_q;
    result_d     = '0;
    fin          = 1'b0;
    fin_st       = ST_OK;

    case (item_i.kind)
      KIND_ISSUE: begin
        if (phase_q != PH_IDLE) begin
          result_d.ev     = EV_REJECT;
          result_d.status = ST_BUSY;
        end else if (item_i.cmd == CMD_BAD) begin
          result_d.ev     = EV_REJECT;
          result_d.status = ST_PROTO;
        end else begin
          result_d.ev              = EV_SENT;
          result_d.status          = ST_OK;
          result_d.send_func       = item_i.func;
          result_d.send_address    = item_i.addr;
          result_d.send_reg_count  = item_i.reg_count;
          result_d.send_data_bytes = item_i.data_bytes;
          phase_d     = (item_i.cmd == CMD_READ) ? PH_READ : PH_WRITE;
          pend_w1_d   = (item_i.cmd == CMD_WRITE1);
          pend_addr_d = item_i.addr;
          pend_elen_d = item_i.expect_len;
          elapsed_d   = '0;
          if (item_i.cmd == CMD_WRITE1) begin
            pend_value_d = item_i.value;
          end
        end
      end
      KIND_REPLY: begin
        if (phase_q != PH_IDLE) begin
          fin = 1'b1;
          if (item_i.reply_len == 8'd0) begin
            fin_st = ST_PROTO;
          end else if (phase_q == PH_READ) begin
            fin_st = (item_i.reply_len == pend_elen_q) ? ST_OK : ST_PROTO;
          end else if (item_i.reply_len < 8'd4 ||
                       item_i.reply_head[31:16] != pend_addr_q) begin
            fin_st = ST_PROTO;
          end else if (pend_w1_q) begin
            if (item_i.reply_head[15:0] == REJECT_VALUE) begin
              fin_st = ST_MODBUS;
            end else if (item_i.reply_head[15:0] != pend_value_q) begin
              fin_st = ST_INVALID;
            end else begin
              fin_st = ST_OK;
            end
          end else begin
            fin_st = ST_OK;
          end
        end
      end
      KIND_EXCEPT: begin
        if (phase_q != PH_IDLE) begin
          fin    = 1'b1;
          fin_st = ST_MODBUS;
        end
      end
      KIND_TICK: begin
        if (phase_q != PH_IDLE) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc > {1'b0, timeout_q}) begin
            fin    = 1'b1;
            fin_st = ST_TIMEOUT;
          end
        end
      end
      default: begin
        result_d = '0;
      end
    endcase

    // Close the transaction
    if (fin) begin
      phase_d         = PH_IDLE;
      result_d.ev     = (fin_st == ST_OK) ? EV_OK : EV_ERR;
      result_d.status = fin_st;
    end

    result_d.busy       = (phase_d != PH_IDLE);
    result_d.write_wait = (phase_d == PH_WRITE);
  end

  // Hold transaction state and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      pend_w1_q    <= 1'b0;
      pend_addr_q  <= '0;
      pend_elen_q  <= '0;
      pend_value_q <= '0;
      elapsed_q    <= '0;
      timeout_q    <= TIMEOUT_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        timeout_q <= cfg_data_i;
      end
      if (pop_o) begin
        phase_q      <= phase_d;
        pend_w1_q    <= pend_w1_d;
        pend_addr_q  <= pend_addr_d;
        pend_elen_q  <= pend_elen_d;
        pend_value_q <= pend_value_d;
        elapsed_q    <= elapsed_d;
        out_valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      result_q <= result_d;
    end
  end

endmodule

/* design/modbus_master_transaction_checker.sv */
// Modbus master transaction checker: front classifier, request queue, back executor.
// The input is written into the queue, then the back end loads the output register from
// it. Throughput: one request per cycle; the back end takes one queued request per cycle
// while its output register is free or draining, and input stall rises only while the
// queue is full behind a stalled output.
// Reset (async, active low): phase idle, pending fields and tick count cleared,
// timeout_ticks back to 4000, queue and output register empty.
module modbus_master_transaction_checker #(
  parameter int QUEUE_DEPTH = mbtc_pkg::MBTC_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  func_code_i,
  input  logic [15:0] reg_address_i,
  input  logic [7:0]  expect_len_i,
  input  logic [7:0]  payload_len_i,
  input  logic [15:0] payload_word_i,
  input  logic [7:0]  reply_len_i,
  input  logic [31:0] reply_head_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_res_o,
  output logic [2:0]  status_o,
  output logic [7:0]  send_func_o,
  output logic [15:0] send_address_o,
  output logic [7:0]  send_reg_count_o,
  output logic [8:0]  send_data_bytes_o,
  output logic        busy_res_o,
  output logic        write_wait_o
);
  import mbtc_pkg::*;

  logic    push, pop, full, empty;
  item_t   push_item, pop_item;
  result_t result;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;

  mbtc_front u_front (
    .in_valid_i     (in_valid_i),
    .queue_full_i   (full),
    .kind_i         (kind_i),
    .func_code_i    (func_code_i),
    .reg_address_i  (reg_address_i),
    .expect_len_i   (expect_len_i),
    .payload_len_i  (payload_len_i),
    .payload_word_i (payload_word_i),
    .reply_len_i    (reply_len_i),
    .reply_head_i   (reply_head_i),
    .push_o         (push),
    .item_o         (push_item)
  );

  mbtc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .full_o      (full),
    .empty_o     (empty),
    .pop_item_o  (pop_item)
  );

  mbtc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .empty_i     (empty),
    .item_i      (pop_item),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .result_o    (result)
  );

  // Unpack the result register onto the ports
  assign event_res_o       = result.ev;
  assign status_o          = result.status;
  assign send_func_o       = result.send_func;
  assign send_address_o    = result.send_address;
  assign send_reg_count_o  = result.send_reg_count;
  assign send_data_bytes_o = result.send_data_bytes;
  assign busy_res_o        = result.busy;
  assign write_wait_o      = result.write_wait;

endmodule

/* tb/modbus_master_transaction_checker_tb.sv */
// Self-checking testbench for the Modbus master transaction checker.
// Predicts each outcome in a scoreboard class and drives requests, replies and ticks under
// random gaps and output stalls. Depends on mbtc_pkg and the checker's top level.
module modbus_master_transaction_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mbtc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  typedef enum logic [1:0] {
    TXN_IDLE  = 2'd0,
    TXN_READ  = 2'd1,
    TXN_WRITE = 2'd2
  } txn_phase_e;

  // One request as presented on the input channel
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  func;
    logic [15:0] addr;
    logic [7:0]  expect_len;
    logic [7:0]  payload_len;
    logic [15:0] payload_word;
    logic [7:0]  reply_len;
    logic [31:0] reply_head;
  } mb_request_t;

  // Tracks the transaction state and holds the outcomes still owed by the block
  class txn_outcome_board;
    logic [15:0] timeout_ticks;
    txn_phase_e  phase;
    logic [7:0]  pend_func;
    logic [15:0] pend_addr;
    logic [7:0]  pend_expect_len;
    logic [15:0] pend_value;
    logic [16:0] elapsed;
    result_t     outcome_q[$];
    int          fail_count;
    int          requests;
    int          checked;

    function new();
      timeout_ticks   = TIMEOUT_RESET;
      phase           = TXN_IDLE;
      pend_func       = '0;
      pend_addr       = '0;
      pend_expect_len = '0;
      pend_value      = '0;
      elapsed         = '0;
      fail_count      = 0;
      requests        = 0;
      checked         = 0;
    endfunction

    function void set_timeout(logic [15:0] v);
      timeout_ticks = v;
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction

    // End the waiting transaction with the given status
    function void close_txn(inout result_t e, input status_e st);
      phase    = TXN_IDLE;
      e.ev     = (st == ST_OK) ? EV_OK : EV_ERR;
      e.status = st;
    endfunction

    // Predict the outcome of one accepted request and queue it
    function void accept_request(mb_request_t r);
      result_t     e;
      logic [8:0]  padded;
      logic [15:0] echo_addr;
      logic [15:0] echo_val;
      e         = '0;
      padded    = {1'b0, r.payload_len} + {8'd0, r.payload_len[0]};
      echo_addr = r.reply_head[31:16];
      echo_val  = r.reply_head[15:0];
      case (r.kind)
        KIND_ISSUE: begin
          if (phase != TXN_IDLE) begin
            e.ev     = EV_REJECT;
            e.status = ST_BUSY;
          end else if (r.func == FC_READ || r.func == FC_WRITEN ||
                       (r.func == FC_WRITE1 && padded == 9'd2)) begin
            e.ev           = EV_SENT;
            e.status       = ST_OK;
            e.send_func    = r.func;
            e.send_address = r.addr;
            if (r.func == FC_READ) begin
              e.send_reg_count = r.expect_len >> 1;
              phase = TXN_READ;
            end else if (r.func == FC_WRITE1) begin
              e.send_data_bytes = 9'd2;
              pend_value = (r.payload_len == 8'd1) ? {r.payload_word[15:8], PAD_BYTE}
                                                   : r.payload_word;
              phase = TXN_WRITE;
            end else begin
              e.send_reg_count  = padded[8:1];
              e.send_data_bytes = padded;
              phase = TXN_WRITE;
            end
            pend_func       = r.func;
            pend_addr       = r.addr;
            pend_expect_len = r.expect_len;
            elapsed         = '0;
          end else begin
            e.ev     = EV_REJECT;
            e.status = ST_PROTO;
          end
        end
        KIND_REPLY: begin
          if (phase != TXN_IDLE) begin
            if (r.reply_len == 8'd0) begin
              close_txn(e, ST_PROTO);
            end else if (phase == TXN_READ) begin
              close_txn(e, (r.reply_len == pend_expect_len) ? ST_OK : ST_PROTO);
            end else if (r.reply_len < 8'd4 || echo_addr != pend_addr) begin
              close_txn(e, ST_PROTO);
            end else if (pend_func == FC_WRITE1) begin
              if (echo_val == REJECT_VALUE) close_txn(e, ST_MODBUS);
              else if (echo_val != pend_value) close_txn(e, ST_INVALID);
              else close_txn(e, ST_OK);
            end else begin
              close_txn(e, ST_OK);
            end
          end
        end
        KIND_EXCEPT: begin
          if (phase != TXN_IDLE) close_txn(e, ST_MODBUS);
        end
        default: begin
          // Count the tick, saturating, and time out once past the limit
          if (phase != TXN_IDLE) begin
            if (elapsed < TICKS_MAX) elapsed = elapsed + 17'd1;
            if (elapsed > {1'b0, timeout_ticks}) close_txn(e, ST_TIMEOUT);
          end
        end
      endcase
      e.busy       = (phase != TXN_IDLE);
      e.write_wait = (phase == TXN_WRITE);
      outcome_q = {outcome_q, e};
      requests++;
    endfunction

    task report(string what);
      fail_count++;
      if (fail_count <= 40) $display("MISMATCH outcome %0d: %s", checked, what);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // Compare one accepted outcome against the oldest prediction
    task check_outcome(result_t got);
      result_t e;
      if (outcome_q.size() == 0) begin
        report($sformatf("unexpected outcome event %0d status %0d", got.ev, got.status));
        return;
      end
      e = outcome_q.pop_front();
      checked++;
      compare_field("event_res", 32'(got.ev), 32'(e.ev));
      compare_field("status", 32'(got.status), 32'(e.status));
      compare_field("send_func", 32'(got.send_func), 32'(e.send_func));
      compare_field("send_address", 32'(got.send_address), 32'(e.send_address));
      compare_field("send_reg_count", 32'(got.send_reg_count), 32'(e.send_reg_count));
      compare_field("send_data_bytes", 32'(got.send_data_bytes), 32'(e.send_data_bytes));
      compare_field("busy_res", 32'(got.busy), 32'(e.busy));
      compare_field("write_wait", 32'(got.write_wait), 32'(e.write_wait));
    endtask
  endclass

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        cfg_valid_i       = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i        = '0;
  logic        in_valid_i        = 1'b0;
  logic        in_stall_o;
  logic [1:0]  kind_i            = '0;
  logic [7:0]  func_code_i       = '0;
  logic [15:0] reg_address_i     = '0;
  logic [7:0]  expect_len_i      = '0;
  logic [7:0]  payload_len_i     = '0;
  logic [15:0] payload_word_i    = '0;
  logic [7:0]  reply_len_i       = '0;
  logic [31:0] reply_head_i      = '0;
  logic        out_valid_o;
  logic        out_stall_i       = 1'b0;
  logic [2:0]  event_res_o;
  logic [2:0]  status_o;
  logic [7:0]  send_func_o;
  logic [15:0] send_address_o;
  logic [7:0]  send_reg_count_o;
  logic [8:0]  send_data_bytes_o;
  logic        busy_res_o;
  logic        write_wait_o;

  txn_outcome_board board;
  logic             idle_off     = 1'b0;
  logic [15:0]      cur_timeout  = TIMEOUT_RESET;
  int unsigned      cycle_count  = 0;
  int               settings_run = 1;

  modbus_master_transaction_checker dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .kind_i            (kind_i),
    .func_code_i       (func_code_i),
    .reg_address_i     (reg_address_i),
    .expect_len_i      (expect_len_i),
    .payload_len_i     (payload_len_i),
    .payload_word_i    (payload_word_i),
    .reply_len_i       (reply_len_i),
    .reply_head_i      (reply_head_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .event_res_o       (event_res_o),
    .status_o          (status_o),
    .send_func_o       (send_func_o),
    .send_address_o    (send_address_o),
    .send_reg_count_o  (send_reg_count_o),
    .send_data_bytes_o (send_data_bytes_o),
    .busy_res_o        (busy_res_o),
    .write_wait_o      (write_wait_o)
  );

  // Generate the 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Abort a run that hangs
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (idle_off) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 10);
    else return $urandom_range(20, 60);
  endfunction

  function automatic mb_request_t random_request(kind_e k);
    mb_request_t r;
    r.kind         = k;
    r.func         = 8'($urandom);
    r.addr         = 16'($urandom);
    r.expect_len   = 8'($urandom);
    r.payload_len  = 8'($urandom);
    r.payload_word = 16'($urandom);
    r.reply_len    = 8'($urandom);
    r.reply_head   = $urandom;
    return r;
  endfunction

  function automatic mb_request_t issue_request(logic [7:0] fc, logic [15:0] addr,
                                                logic [7:0] elen, logic [7:0] plen,
                                                logic [15:0] pword);
    mb_request_t r;
    r              = random_request(KIND_ISSUE);
    r.func         = fc;
    r.addr         = addr;
    r.expect_len   = elen;
    r.payload_len  = plen;
    r.payload_word = pword;
    return r;
  endfunction

  function automatic mb_request_t reply_request(logic [7:0] len, logic [31:0] head);
    mb_request_t r;
    r            = random_request(KIND_REPLY);
    r.reply_len  = len;
    r.reply_head = head;
    return r;
  endfunction

  // Present one request, hold it until accepted, then leave a random gap
  task automatic drive_request(mb_request_t r);
    int gap;
    in_valid_i     <= 1'b1;
    kind_i         <= r.kind;
    func_code_i    <= r.func;
    reg_address_i  <= r.addr;
    expect_len_i   <= r.expect_len;
    payload_len_i  <= r.payload_len;
    payload_word_i <= r.payload_word;
    reply_len_i    <= r.reply_len;
    reply_head_i   <= r.reply_head;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.accept_request(r);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drain all outcomes, then write the timeout register
  task automatic write_timeout(logic [15:0] v);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    board.set_timeout(v);
    cur_timeout = v;
    settings_run++;
  endtask

  // One transaction, mostly well formed, sometimes broken or pure noise
  task automatic run_random_transaction();
    mb_request_t cmd;
    logic [15:0] echo_val;
    logic [15:0] flip16;
    logic [7:0]  flip8;
    logic [7:0]  rlen;
    logic [31:0] head;
    int          sel;
    int          n_ticks;
    if ($urandom_range(0, 19) == 0) idle_off = !idle_off;
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      repeat ($urandom_range(1, 3)) drive_request(random_request(kind_e'($urandom_range(0, 3))));
      return;
    end
    cmd = random_request(KIND_ISSUE);
    case ($urandom_range(0, 2))
      0: begin
        cmd.func = FC_READ;
        if ($urandom_range(0, 9) == 0) cmd.expect_len = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      1: begin
        cmd.func = FC_WRITE1;
        if ($urandom_range(0, 9) != 0) cmd.payload_len = 8'($urandom_range(1, 2));
      end
      default: begin
        cmd.func = FC_WRITEN;
        if ($urandom_range(0, 7) == 0) cmd.payload_len = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
    endcase
    drive_request(cmd);
    // Now and then try a second command while the first waits
    if ($urandom_range(0, 6) == 0) drive_request(random_request(KIND_ISSUE));
    n_ticks = (cur_timeout < 16'd8) ? $urandom_range(0, cur_timeout + 1) : $urandom_range(0, 3);
    repeat (n_ticks) drive_request(random_request(KIND_TICK));

    echo_val = 16'($urandom);
    if (cmd.func == FC_WRITE1)
      echo_val = (cmd.payload_len == 8'd1) ? {cmd.payload_word[15:8], PAD_BYTE}
                                           : cmd.payload_word;
    rlen = 8'($urandom_range(4, 255));
    if (cmd.func == FC_READ) rlen = cmd.expect_len;
    head   = {cmd.addr, echo_val};
    flip8  = 8'($urandom_range(1, 255));
    flip16 = 16'($urandom_range(1, 65535));
    sel    = $urandom_range(0, 99);
    if (sel < 45) begin
      drive_request(reply_request(rlen, head));
    end else if (sel < 75) begin
      // Break the reply in one way
      case ($urandom_range(0, 4))
        0: rlen = 8'h00;
        1: begin
          if (cmd.func == FC_READ) rlen = rlen ^ flip8;
          else rlen = 8'($urandom_range(0, 3));
        end
        2: head[31:16] = head[31:16] ^ flip16;
        3: head[15:0] = REJECT_VALUE;
        default: head[15:0] = head[15:0] ^ flip16;
      endcase
      drive_request(reply_request(rlen, head));
    end else if (sel < 88) begin
      drive_request(random_request(KIND_EXCEPT));
    end else if (cur_timeout < 16'd8) begin
      repeat (cur_timeout + 2) drive_request(random_request(KIND_TICK));
    end else begin
      drive_request(reply_request(rlen, head));
    end
  endtask

  // Check every accepted outcome and stall the output at random
  initial begin : outcome_monitor
    int stall_left;
    int run_left;
    stall_left = 0;
    run_left   = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_stall_i == 1'b0)
        board.check_outcome(result_t'({event_res_o, status_o, send_func_o, send_address_o,
                                       send_reg_count_o, send_data_bytes_o, busy_res_o,
                                       write_wait_o}));
      if (idle_off) begin
        out_stall_i <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if (run_left > 0) begin
        out_stall_i <= 1'b0;
        run_left--;
      end else begin
        stall_left = pick_gap();
        run_left   = $urandom_range(0, 15);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Main stimulus
  initial begin : stimulus
    int unsigned settings[6];
    int          phase_start;
    board = new();
    settings = '{0, 1, 65535, 2, 5, 0};
    settings[5] = $urandom_range(0, 6);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: replies, exceptions and ticks while idle are ignored
    drive_request(reply_request(8'd4, 32'h1234_5678));
    drive_request(random_request(KIND_EXCEPT));
    drive_request(random_request(KIND_TICK));
    // Read at the field extremes, a busy command, then a matching reply
    drive_request(issue_request(FC_READ, 16'hFFFF, 8'hFF, 8'h00, 16'h0000));
    drive_request(issue_request(FC_WRITEN, 16'h0001, 8'h02, 8'h04, 16'h1111));
    drive_request(reply_request(8'hFF, 32'h0000_0000));
    // Empty reply, then a read reply of the wrong length
    drive_request(issue_request(FC_READ, 16'h0000, 8'h00, 8'hFF, 16'hFFFF));
    drive_request(reply_request(8'h00, 32'hFFFF_FFFF));
    drive_request(issue_request(FC_READ, 16'h0100, 8'd10, 8'd0, 16'h0000));
    drive_request(reply_request(8'd9, 32'h0100_0000));
    // Single write padded from one byte, echoed correctly
    drive_request(issue_request(FC_WRITE1, 16'h00A5, 8'd0, 8'd1, 16'hABCD));
    drive_request(reply_request(8'd4, 32'h00A5_AB00));
    // Single write answered with the reject value, then with a wrong echo
    drive_request(issue_request(FC_WRITE1, 16'hFFFF, 8'hFF, 8'd2, 16'h5A5A));
    drive_request(reply_request(8'hFF, 32'hFFFF_FFFF));
    drive_request(issue_request(FC_WRITE1, 16'h8000, 8'd0, 8'd2, 16'h0001));
    drive_request(reply_request(8'd4, 32'h8000_0002));
    // Single write with a payload that does not pad to two bytes
    drive_request(issue_request(FC_WRITE1, 16'h0002, 8'd0, 8'd0, 16'h1234));
    drive_request(issue_request(FC_WRITE1, 16'h0003, 8'd0, 8'd3, 16'h1234));
    // Multiple write: empty payload with short reply, largest payload with address mismatch
    drive_request(issue_request(FC_WRITEN, 16'h7FFF, 8'd0, 8'd0, 16'h0000));
    drive_request(reply_request(8'd3, 32'h7FFF_0000));
    drive_request(issue_request(FC_WRITEN, 16'h4242, 8'd0, 8'hFF, 16'hFFFF));
    drive_request(reply_request(8'd4, 32'h4243_0000));
    drive_request(issue_request(FC_WRITEN, 16'h0F0F, 8'd0, 8'hFE, 16'h0000));
    drive_request(reply_request(8'hFF, 32'h0F0F_1234));
    // Unknown function codes, then an exception reply
    drive_request(issue_request(8'h00, 16'h0000, 8'd0, 8'd2, 16'h0000));
    drive_request(issue_request(8'hFF, 16'hFFFF, 8'hFF, 8'd2, 16'hFFFF));
    drive_request(issue_request(FC_READ, 16'h1357, 8'd4, 8'd0, 16'h0000));
    drive_request(random_request(KIND_EXCEPT));

    // Random transactions under several timeout settings
    foreach (settings[s]) begin
      write_timeout(16'(settings[s]));
      idle_off    = 1'b0;
      phase_start = board.requests;
      while (board.requests - phase_start < 117) run_random_transaction();
    end

    // Drain, then allow for any stray outcome
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d requests under %0d timeout settings, %0d outcomes checked",
             board.requests, settings_run, board.checked);
    $display("Mismatches seen: %0d", board.fail_count);
    if (board.fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/mbtc_pkg.sv
design/mbtc_front.sv
design/mbtc_queue.sv
design/mbtc_back.sv
design/modbus_master_transaction_checker.sv
tb/modbus_master_transaction_checker_tb.sv
